// ----- sv/mr_pkg.sv -----
// ----------------------------------------------------------------------------
// mr_pkg
// Types, sizes and codes shared by the multinomial resampler cells and top.
// ----------------------------------------------------------------------------
package mr_pkg;

    localparam int PARTICLE_COUNT = 256;

    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 16;
    localparam int SUM_W    = 24;
    localparam int INDEX_W  = 8;
    localparam int PROD_W   = FRAC_W + SUM_W;

    // each cell holds ENTRY_COUNT consecutive sums
    localparam int SLOT_W      = 4;
    localparam int ENTRY_COUNT = 1 << SLOT_W;
    localparam int LCNT_W      = SLOT_W + 1;
    localparam int CELL_COUNT  = (PARTICLE_COUNT + ENTRY_COUNT - 1) / ENTRY_COUNT;
    localparam int CELL_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int GIDX_W      = CELL_W + SLOT_W;
    localparam int CNT_W       = $clog2(PARTICLE_COUNT + 1);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [WEIGHT_W-1:0] weight_value;
        logic [FRAC_W-1:0]   draw_fraction;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] source_index;
        logic               empty_error;
    } out_item_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              wr_en;
        logic [GIDX_W-1:0] wr_idx;
        logic [SUM_W-1:0]  wr_sum;
        logic              cmp_en;
        logic [SUM_W-1:0]  target;
        logic [GIDX_W-1:0] last_idx;
    } cell_ctrl_t;

    // running count handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [GIDX_W-1:0] acc;
    } link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_CMP,
        ST_LAUNCH,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

// ----- sv/mr_cell.sv -----
// ----------------------------------------------------------------------------
// mr_cell
// One cell of the sum chain: stores a slice of the cumulative table, counts
// its entries below the draw target and adds that count to the passing total.
// ----------------------------------------------------------------------------
module mr_cell import mr_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CELL_W-1:0] cell_id,
    input  cell_ctrl_t        ctrl,
    input  link_t             link_in,
    output link_t             link_out
);

    logic [SUM_W-1:0]       sum_reg [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] below;
    logic [LCNT_W-1:0]      cnt_reg, cnt_next;
    logic                   valid_reg;
    logic [GIDX_W-1:0]      acc_reg;
    logic                   wr_hit;

    assign wr_hit = ctrl.wr_en && (ctrl.wr_idx[GIDX_W-1:SLOT_W] == cell_id);

    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            sum_reg[ctrl.wr_idx[SLOT_W-1:0]] <= ctrl.wr_sum;
        end
    end

    // entries at or past the last loaded one never count, so the flags
    // form a run of ones followed by zeros
    always_comb begin
        for (int j = 0; j < ENTRY_COUNT; j++) begin
            below[j] = ({cell_id, SLOT_W'(j)} < ctrl.last_idx) &&
                       (sum_reg[j] < ctrl.target);
        end
    end

    always_comb begin
        cnt_next = LCNT_W'(ENTRY_COUNT);
        for (int j = ENTRY_COUNT - 1; j >= 0; j--) begin
            if (!below[j]) begin
                cnt_next = LCNT_W'(j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            cnt_reg <= cnt_next;
        end
        if (link_in.valid) begin
            acc_reg <= link_in.acc + GIDX_W'(cnt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= link_in.valid;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.acc   = acc_reg;

endmodule

// ----- sv/multinomial_resampler_unit.sv -----
// ----------------------------------------------------------------------------
// multinomial_resampler_unit
// Multinomial resampling draw engine: builds a cumulative weight table from
// load requests and maps uniform fractions to particle indices.
// ----------------------------------------------------------------------------
//  channel   dir   handshake           payload
//  s_        in    s_valid / s_ready   in_item_t  (kind, weight, fraction)
//  m_        out   m_valid / m_ready   out_item_t (source index, empty flag)
//
//  Load and clear requests are handled in the idle state, which stays ready.
//  A draw steps through one multiply, one compare in all cells and a launch,
//  then the running count ripples one cell a cycle.
//  A draw on an empty table goes straight to the done state, empty flag set.
//  Reset empties the table; the sums themselves are not cleared.
//  A pending result waits in the output register; loads go on meanwhile.
// ----------------------------------------------------------------------------
module multinomial_resampler_unit import mr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] last_sum_reg, last_sum_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [SUM_W-1:0] target_reg, target_next;
    out_item_t        pend_reg, pend_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    cell_ctrl_t       ctrl;
    link_t            links [CELL_COUNT + 1];
    logic             start;
    logic             accept;
    logic             out_free;

    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        sum_sat;
    logic [PROD_W-1:0]       prod;
    logic [CNT_W-1:0]        count_m1;
    logic [CNT_W+GIDX_W-1:0] count_ext, last_ext;
    logic [GIDX_W+INDEX_W-1:0] acc_ext;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign sum_wide  = {1'b0, last_sum_reg} + (SUM_W + 1)'(s_data.weight_value);
    assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign prod      = PROD_W'(frac_reg) * PROD_W'(last_sum_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_ext = {{GIDX_W{1'b0}}, count_reg};
    assign last_ext  = {{GIDX_W{1'b0}}, count_m1};
    assign acc_ext   = {{INDEX_W{1'b0}}, links[CELL_COUNT].acc};

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_sum_next = last_sum_reg;
        frac_next     = frac_reg;
        target_next   = target_reg;
        pend_next     = pend_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        ctrl.wr_en    = 1'b0;
        ctrl.wr_idx   = count_ext[GIDX_W-1:0];
        ctrl.wr_sum   = (count_reg == '0) ? SUM_W'(s_data.weight_value) : sum_sat;
        ctrl.cmp_en   = 1'b0;
        ctrl.target   = target_reg;
        ctrl.last_idx = last_ext[GIDX_W-1:0];
        start         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.kind)
                        KIND_LOAD: begin
                            if (count_reg < CNT_W'(PARTICLE_COUNT)) begin
                                ctrl.wr_en    = 1'b1;
                                last_sum_next = ctrl.wr_sum;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_DRAW: begin
                            if (count_reg == '0) begin
                                pend_next.source_index = '0;
                                pend_next.empty_error  = 1'b1;
                                state_next             = ST_DONE;
                            end else begin
                                frac_next  = s_data.draw_fraction;
                                state_next = ST_MULT;
                            end
                        end
                        KIND_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MULT: begin
                target_next = prod[PROD_W-1:FRAC_W];
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                ctrl.cmp_en = 1'b1;
                state_next  = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                start      = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (links[CELL_COUNT].valid) begin
                    pend_next.source_index = acc_ext[INDEX_W-1:0];
                    pend_next.empty_error  = 1'b0;
                    state_next             = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_sum_reg <= last_sum_next;
        frac_reg     <= frac_next;
        target_reg   <= target_next;
        pend_reg     <= pend_next;
        m_data_reg   <= m_data_next;
    end

    assign links[0].valid = start;
    assign links[0].acc   = '0;

    for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
        mr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_id  (CELL_W'(c)),
            .ctrl     (ctrl),
            .link_in  (links[c]),
            .link_out (links[c + 1])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the count only leaves the chain while a draw is walking
    a_walk_only: assert property (@(posedge aclk) disable iff (!aresetn)
        links[CELL_COUNT].valid |-> state_reg == ST_WALK)
        else $error("chain result outside walk");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PARTICLE_COUNT))
        else $error("table count past depth");

    a_empty_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.empty_error) |-> m_data_reg.source_index == '0)
        else $error("empty draw with nonzero index");

    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished draw not delivered");

endmodule
